### rtl/core/qptrk_pkg.sv
`timescale 1ns / 1ps

package qptrk_pkg;

   // register indexes on the configuration channel
   localparam logic [1:0] CSR_AUTO_RELOAD  = 2'd0;
   localparam logic [1:0] CSR_COUNTS_PER_REV = 2'd1;
   localparam logic [1:0] CSR_ANGLE_OFFSET = 2'd2;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   // one full electrical turn in 1/64 degree units
   localparam int FULL_TURN   = 23040;
   localparam int QUO_WIDTH   = 15;
   localparam int PROD_WIDTH  = 47;
   localparam int SUM_WIDTH   = 18;

   localparam int REQ_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 96;
   localparam int RSP_USER_WIDTH = 2;

   localparam logic [31:0] AUTO_RELOAD_RESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNTS_PER_REV_RESET = 32'd4096;

   typedef struct packed {
      logic capture;   // take the input transfer
      logic update;    // delta, position, alignment; seed the divider
      logic div_step;  // one restoring divide step
      logic scale;     // multiply remainder by one full turn
      logic load_div;  // seed the divider with the scaled remainder
      logic send;      // load the result register
   } cmd_type;

   typedef struct packed {
      logic angle_needed;
      logic divisor_zero;
      logic out_free;
   } stat_type;

endpackage

### rtl/core/quadrature_position_velocity_tracker.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_tvalid/tready    tdata: enc_count, index_count; tuser: counting_down
// rsp       out        rsp_tvalid/tready    tdata: position, velocity, phase_angle;
//                                           tuser: index_found, clear_counter
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// An aligned tick with a nonzero counts-per-revolution runs the modulo and the angle scaling
// through the divider; other ticks go from update straight to send. The shared restoring
// divider does one bit per cycle: COUNT_WIDTH steps for the modulo, 15 for the angle scaling.
// Reset is synchronous, active high; configuration returns to its reset values.
// A finished result waits in the output register; the next tick is accepted meanwhile
// and only its final load waits for rsp_tready.

module quadrature_position_velocity_tracker #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [qptrk_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,   // enc_count, index_count
   input  logic                                  req_tuser,   // counting_down
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [qptrk_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,   // position, velocity, phase_angle
   output logic [qptrk_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser,   // index_found, clear_counter
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [qptrk_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [qptrk_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import qptrk_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   qptrk_ctrl #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   qptrk_dpath #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   // a counter clear only comes with alignment
   a_clear_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("clear_counter without index_found");

   // no angle before alignment
   a_angle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[94:80] == '0)
      else $error("phase_angle nonzero before alignment");

   // angle stays within one turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[94:80] < 15'(FULL_TURN))
      else $error("phase_angle out of range");

   // one tick at a time: ready drops after an input transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while busy");

   // a result is loaded only when the output slot is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.send |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

endmodule

### rtl/core/qptrk_ctrl.sv
`timescale 1ns / 1ps

module qptrk_ctrl #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  qptrk_pkg::stat_type stat,
   output qptrk_pkg::cmd_type  cmd
);
   import qptrk_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_UPDATE = 7'b0000010,
      ST_MOD    = 7'b0000100,
      ST_SCALE  = 7'b0001000,
      ST_LOAD   = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_SEND   = 7'b1000000
   } state_type;

   localparam int StepBits = $clog2(COUNT_WIDTH);
   localparam logic [StepBits-1:0] ModLast = StepBits'(COUNT_WIDTH - 1);
   localparam logic [StepBits-1:0] DivLast = StepBits'(QUO_WIDTH - 1);

   state_type           state_ff, state_in;
   logic [StepBits-1:0] step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (stat.angle_needed && !stat.divisor_zero) begin
               state_in = ST_MOD;
               step_in  = ModLast;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_MOD: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SCALE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            step_in      = DivLast;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SEND;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SEND: begin
            // hold until the result register is free
            if (stat.out_free) begin
               cmd.send = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### rtl/core/qptrk_dpath.sv
`timescale 1ns / 1ps

module qptrk_dpath #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [qptrk_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [qptrk_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic [qptrk_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [qptrk_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic [qptrk_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser,
   input  qptrk_pkg::cmd_type                    cmd,
   output qptrk_pkg::stat_type                   stat
);
   import qptrk_pkg::*;

   localparam int CW = COUNT_WIDTH;
   localparam logic signed [SUM_WIDTH-1:0] TurnS    = SUM_WIDTH'(FULL_TURN);
   localparam logic signed [SUM_WIDTH-1:0] TwoTurnS = SUM_WIDTH'(2 * FULL_TURN);
   localparam logic signed [SUM_WIDTH-1:0] NegTurnS = SUM_WIDTH'(-FULL_TURN);

   // configuration
   logic [31:0]        auto_reload_ff;
   logic [31:0]        counts_rev_ff;
   logic signed [15:0] offset_ff;

   // captured input
   logic [CW-1:0] cnt_cap_ff;
   logic          down_ff;
   logic [31:0]   idx_cap_ff;

   // tracking state
   logic [CW-1:0] prev_count_ff;
   logic          started_ff;
   logic [63:0]   position_ff;
   logic [31:0]   prev_idx_ff;
   logic          aligned_ff;
   logic          clear_ff;
   logic [15:0]   vel_ff;

   // divider
   logic [31:0]            rem_ff;
   logic [CW-1:0]          dvd_ff;
   logic [QUO_WIDTH-1:0]   quo_ff;
   logic [PROD_WIDTH-1:0]  prod_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [63:0]           rsp_pos_ff;
   logic [15:0]           rsp_vel_ff;
   logic [QUO_WIDTH-1:0]  rsp_angle_ff;
   logic                  rsp_found_ff;
   logic                  rsp_clear_ff;

   logic                        align;
   logic [CW-1:0]               cnt_eff;
   logic [15:0]                 diff16, wrap16, delta16, vel_calc;
   logic [32:0]                 trial, trial_sub;
   logic                        ge;
   logic [31:0]                 rem_in;
   logic signed [SUM_WIDTH-1:0] sum, wrapped;
   logic [QUO_WIDTH-1:0]        angle;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_reload_ff <= AUTO_RELOAD_RESET;
         counts_rev_ff  <= COUNTS_PER_REV_RESET;
         offset_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AUTO_RELOAD:    auto_reload_ff <= csr_data;
            CSR_COUNTS_PER_REV: counts_rev_ff  <= csr_data;
            CSR_ANGLE_OFFSET:   offset_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // alignment on the first rise of the index counter
   assign align   = !aligned_ff && (idx_cap_ff > prev_idx_ff);
   assign cnt_eff = align ? '0 : cnt_cap_ff;

   // only the low 16 bits of the delta survive, so work at 16 bits
   assign diff16 = cnt_eff[15:0] - prev_count_ff[15:0];
   assign wrap16 = auto_reload_ff[15:0] + 16'd1;

   always_comb begin
      if (cnt_eff == prev_count_ff) begin
         delta16 = '0;
      end else if (cnt_eff > prev_count_ff) begin
         delta16 = down_ff ? (diff16 - wrap16) : diff16;
      end else begin
         delta16 = down_ff ? diff16 : (diff16 + wrap16);
      end
   end

   assign vel_calc = (started_ff && !align) ? delta16 : '0;

   // one restoring divide step
   assign trial     = {rem_ff, dvd_ff[CW-1]};
   assign trial_sub = trial - {1'b0, counts_rev_ff};
   assign ge        = (trial >= {1'b0, counts_rev_ff});
   assign rem_in    = ge ? trial_sub[31:0] : trial[31:0];

   // wrap quotient plus offset into one turn
   assign sum = $signed({{(SUM_WIDTH - QUO_WIDTH){1'b0}}, quo_ff}) + SUM_WIDTH'(offset_ff);

   always_comb begin
      if (sum < NegTurnS) begin
         wrapped = sum + TwoTurnS;
      end else if (sum < 0) begin
         wrapped = sum + TurnS;
      end else if (sum >= TwoTurnS) begin
         wrapped = sum - TwoTurnS;
      end else if (sum >= TurnS) begin
         wrapped = sum - TurnS;
      end else begin
         wrapped = sum;
      end
   end

   assign angle = aligned_ff ? wrapped[QUO_WIDTH-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         started_ff    <= 1'b0;
         position_ff   <= '0;
         prev_idx_ff   <= '0;
         aligned_ff    <= 1'b0;
      end else if (cmd.update) begin
         prev_count_ff <= cnt_eff;
         started_ff    <= 1'b1;
         position_ff   <= align ? '0 : position_ff + {{48{vel_calc[15]}}, vel_calc};
         prev_idx_ff   <= idx_cap_ff;
         aligned_ff    <= aligned_ff | align;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cnt_cap_ff <= req_tdata[CW-1:0];
         down_ff    <= req_tuser;
         idx_cap_ff <= req_tdata[63:32];
      end
      if (cmd.update) begin
         vel_ff   <= vel_calc;
         clear_ff <= align;
         rem_ff   <= '0;
         dvd_ff   <= cnt_eff;
         quo_ff   <= '0;
      end else if (cmd.scale) begin
         prod_ff <= PROD_WIDTH'(rem_ff) * PROD_WIDTH'(FULL_TURN);
      end else if (cmd.load_div) begin
         // quotient fits in QUO_WIDTH bits, so the upper part is already below the divisor
         rem_ff <= prod_ff[PROD_WIDTH-1:QUO_WIDTH];
         dvd_ff <= {prod_ff[QUO_WIDTH-1:0], {(CW - QUO_WIDTH){1'b0}}};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[CW-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_WIDTH-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         rsp_pos_ff   <= position_ff;
         rsp_vel_ff   <= vel_ff;
         rsp_angle_ff <= angle;
         rsp_found_ff <= aligned_ff;
         rsp_clear_ff <= clear_ff;
      end
   end

   assign stat.angle_needed = aligned_ff | align;
   assign stat.divisor_zero = (counts_rev_ff == '0);
   assign stat.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_angle_ff, rsp_vel_ff, rsp_pos_ff};
   assign rsp_tuser  = {rsp_clear_ff, rsp_found_ff};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import qptrk_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 500;
   localparam int DRAIN_WAIT  = 120;

   typedef struct {
      logic [31:0] enc;
      logic        down;
      logic [31:0] idx;
   } tick_item_type;

   typedef struct {
      logic [63:0] position;
      logic [15:0] velocity;
      logic        index_found;
      logic [14:0] phase_angle;
      logic        clear_counter;
   } tick_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata  = '0;   // enc_count, index_count
   logic                       req_tuser  = 1'b0; // counting_down
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;         // position, velocity, phase_angle
   logic [RSP_USER_WIDTH-1:0]  rsp_tuser;         // index_found, clear_counter
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data   = '0;

   quadrature_position_velocity_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // tracker copy: configuration and state
   logic [31:0]        reload_cfg = AUTO_RELOAD_RESET;
   logic [31:0]        rev_cfg    = COUNTS_PER_REV_RESET;
   logic signed [15:0] offset_cfg = '0;
   logic [31:0]        prev_cnt   = '0;
   logic               started    = 1'b0;
   logic [63:0]        pos_acc    = '0;
   logic [31:0]        prev_idx   = '0;
   logic               aligned    = 1'b0;

   tick_item_type   pending_ticks[$];
   tick_result_type expected_ticks[$];

   int err_count     = 0;
   int req_offered   = 0;
   int req_taken     = 0;
   int rsp_count     = 0;
   int rsp_seen      = 0;
   int hold_req_cnt  = 0;
   int hold_ack_cnt  = 0;
   int idle_cycles   = 0;
   int send_gap      = 0;
   int recv_wait     = 0;
   int hold_left     = 0;
   bit send_gaps_on  = 1'b0;
   bit recv_stalls_on = 1'b0;
   bit pause_send    = 1'b0;

   logic [31:0] shaft    = '0;
   logic [31:0] idx_last = '0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] count_delta(logic [31:0] cnt, logic down);
      logic [31:0] top;
      top = reload_cfg;
      if (cnt == prev_cnt) return 32'd0;
      if (cnt > prev_cnt)
         return down ? 32'd0 - (prev_cnt + (top - cnt + 32'd1)) : cnt - prev_cnt;
      return down ? cnt - prev_cnt : cnt + (top - prev_cnt + 32'd1);
   endfunction

   function automatic logic [14:0] angle_at(logic [31:0] cnt);
      longint e, q, s, r, c;
      c = longint'({32'd0, rev_cfg});
      e = 0;
      q = 0;
      if (c != 0) begin
         e = longint'({32'd0, cnt}) % c;
         q = (e * FULL_TURN) / c;
      end
      s = q + longint'(offset_cfg);
      r = s % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      return r[14:0];
   endfunction

   // advance the tracker by one tick and queue what it must report
   function automatic void track_tick(logic [31:0] enc, logic down, logic [31:0] idx);
      tick_result_type res;
      logic [31:0]  cnt;
      logic [31:0]  d;
      logic [15:0]  vel;
      logic         clr;
      cnt = enc;
      vel = '0;
      clr = 1'b0;
      if (!aligned && idx > prev_idx) begin
         cnt      = '0;
         pos_acc  = '0;
         prev_cnt = '0;
         started  = 1'b1;
         aligned  = 1'b1;
         clr      = 1'b1;
      end
      prev_idx = idx;
      if (!started) begin
         started = 1'b1;
      end else begin
         d   = count_delta(cnt, down);
         vel = d[15:0];
      end
      pos_acc  = pos_acc + {{48{vel[15]}}, vel};
      prev_cnt = cnt;
      res.position      = pos_acc;
      res.velocity      = vel;
      res.index_found   = aligned;
      res.phase_angle   = aligned ? angle_at(cnt) : 15'd0;
      res.clear_counter = clr;
      expected_ticks.push_back(res);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      err_count++;
      $display("tb_top: result %0d %s got %h want %h", rsp_count, what, got, want);
   endtask

   // monitor: transfers, prediction, checking, watchdog
   always @(posedge clock) begin : mon
      tick_result_type want;
      bit              moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_AUTO_RELOAD:    reload_cfg = csr_data;
               CSR_COUNTS_PER_REV: rev_cfg    = csr_data;
               CSR_ANGLE_OFFSET:   offset_cfg = csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            rsp_count++;
            if (expected_ticks.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[63:0], '0);
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_tdata[63:0] !== want.position)
                  report_mismatch("position", rsp_tdata[63:0], want.position);
               if (rsp_tdata[79:64] !== want.velocity)
                  report_mismatch("velocity", 64'(rsp_tdata[79:64]), 64'(want.velocity));
               if (rsp_tdata[94:80] !== want.phase_angle)
                  report_mismatch("phase_angle", 64'(rsp_tdata[94:80]),
                                  64'(want.phase_angle));
               if (rsp_tuser[0] !== want.index_found)
                  report_mismatch("index_found", 64'(rsp_tuser[0]), 64'(want.index_found));
               if (rsp_tuser[1] !== want.clear_counter)
                  report_mismatch("clear_counter", 64'(rsp_tuser[1]),
                                  64'(want.clear_counter));
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            track_tick(req_tdata[31:0], req_tuser, req_tdata[63:32]);
            req_taken++;
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // tick driver
   always @(negedge clock) begin : drv
      tick_item_type it;
      if (!reset) begin
         if (req_tvalid && req_taken == req_offered) begin
            send_gap = send_gaps_on ? $urandom_range(0, 16) : 0;
            if (send_gap == 0 && !pause_send && pending_ticks.size() > 0) begin
               it = pending_ticks.pop_front();
               req_tdata <= {it.idx, it.enc};
               req_tuser <= it.down;
               req_offered++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!pause_send && pending_ticks.size() > 0) begin
               it = pending_ticks.pop_front();
               req_tdata  <= {it.idx, it.enc};
               req_tuser  <= it.down;
               req_tvalid <= 1'b1;
               req_offered++;
            end
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = LONG_HOLD;
         end
         if (rsp_seen != rsp_count) begin
            rsp_seen  = rsp_count;
            recv_wait = recv_stalls_on ? $urandom_range(0, 16) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_tick(input logic [31:0] enc, input logic down, input logic [31:0] idx);
      tick_item_type it;
      it.enc  = enc;
      it.down = down;
      it.idx  = idx;
      pending_ticks.push_back(it);
      shaft    = enc;
      idx_last = idx;
   endtask

   // mostly plausible shaft motion inside the reload range, some raw noise
   task automatic queue_motion(input int n, input bit idx_live);
      longint      stride, span, nx;
      logic [31:0] enc, idx;
      logic        down;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            enc  = $urandom;
            down = 1'($urandom_range(0, 1));
         end else begin
            if ($urandom_range(0, 7) == 0) stride = longint'($urandom_range(0, 80000));
            else stride = longint'($urandom_range(0, 400));
            down = 1'($urandom_range(0, 1));
            if (down) stride = -stride;
            span = longint'({32'd0, reload_cfg}) + 1;
            nx   = (longint'({32'd0, shaft}) + stride) % span;
            if (nx < 0) nx += span;
            enc = nx[31:0];
         end
         if (!idx_live) idx = '0;
         else if ($urandom_range(0, 7) == 0) idx = $urandom;
         else idx = idx_last + $urandom_range(0, 1);
         queue_tick(enc, down, idx);
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || expected_ticks.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [31:0] reload, input logic [31:0] rev,
                           input logic signed [15:0] offset);
      write_reg(CSR_AUTO_RELOAD, reload);
      write_reg(CSR_COUNTS_PER_REV, rev);
      write_reg(CSR_ANGLE_OFFSET, {{16{offset[15]}}, offset});
   endtask

   function automatic logic signed [15:0] draw_offset();
      int v;
      v = int'($urandom_range(0, 46078)) - 23039;
      return v[15:0];
   endfunction

   initial begin
      int mark;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // before alignment: first tick, equal counts, both wrap directions
      queue_tick(32'd5, 1'b0, 32'd0);
      queue_tick(32'd5, 1'b0, 32'd0);
      queue_tick(32'd20, 1'b0, 32'd0);
      queue_tick(32'd10, 1'b1, 32'd0);
      queue_tick(32'hFFFF_FFF0, 1'b1, 32'd0);
      queue_tick(32'd8, 1'b0, 32'd0);
      queue_tick(32'hFFFF_FFFF, 1'b0, 32'd0);
      queue_tick(32'd0, 1'b0, 32'd0);
      queue_tick(32'h0001_2345, 1'b1, 32'd0);
      queue_tick(32'h0000_0100, 1'b0, 32'd0);
      wait_idle();

      send_gaps_on   = 1'b1;
      recv_stalls_on = 1'b1;
      queue_motion(100, 1'b0);
      wait_idle();

      // alignment on the first index rise, later rises change nothing
      send_gaps_on   = 1'b0;
      recv_stalls_on = 1'b0;
      queue_tick(32'h0000_0777, 1'b0, 32'd1);
      queue_tick(32'd100, 1'b0, 32'd1);
      queue_tick(32'd4095, 1'b0, 32'd5);
      queue_tick(32'd4096, 1'b0, 32'd0);
      queue_tick(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      queue_tick(32'd0, 1'b0, 32'hFFFF_FFFF);
      wait_idle();

      // long receiver hold while ticks keep coming
      recv_stalls_on = 1'b1;
      mark = req_taken;
      queue_motion(140, 1'b1);
      do @(posedge clock);
      while (req_taken < mark + 30);
      hold_req_cnt++;
      wait_idle();

      set_regs(32'd1, 32'd1, 16'sd23039);
      send_gaps_on = 1'b1;
      queue_motion(60, 1'b1);
      wait_idle();

      // sender pause until everything has drained
      set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd23039);
      mark = req_taken;
      queue_motion(100, 1'b1);
      do @(posedge clock);
      while (req_taken < mark + 50);
      pause_send = 1'b1;
      do @(posedge clock);
      while (req_tvalid || expected_ticks.size() != 0);
      pause_send = 1'b0;
      wait_idle();

      for (int p = 0; p < 3; p++) begin
         set_regs(p == 1 ? $urandom : $urandom_range(1, 200000),
                  $urandom_range(1, 5000), draw_offset());
         send_gaps_on   = (p != 2);
         recv_stalls_on = (p != 0);
         queue_motion(100, 1'b1);
         wait_idle();
      end

      // zero counts per revolution: angle is the wrapped offset
      set_regs($urandom_range(1, 70000), 32'd0, draw_offset());
      send_gaps_on   = 1'b1;
      recv_stalls_on = 1'b1;
      queue_motion(40, 1'b1);
      wait_idle();

      set_regs(32'h0000_FFFF, 32'd3, 16'sd0);
      send_gaps_on   = 1'b0;
      recv_stalls_on = 1'b0;
      queue_motion(80, 1'b1);
      wait_idle();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (err_count == 0 && expected_ticks.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
